>>> design/sm4c_pkg.sv
// Package for the SM4 counter-mode stream cipher core.
// Holds the action codes, controller states, command/status structs and the S-box.
// No dependencies.
`timescale 1ns / 1ps

package sm4c_pkg;

   localparam int unsigned RoundCount = 32;
   localparam int unsigned BlockBytes = 16;
   localparam int unsigned RoundIdxW  = $clog2(RoundCount);
   localparam int unsigned OffsetW    = $clog2(BlockBytes);

   typedef enum logic [1:0] {
      ACT_LOAD_KEY = 2'd0,
      ACT_LOAD_CTR = 2'd1,
      ACT_DATA     = 2'd2,
      ACT_UNUSED   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic                 load_key;
      logic                 load_ctr;
      logic                 start_block;
      logic                 step_round;
      logic                 emit;
      logic                 emit_latched;
      logic [RoundIdxW-1:0] round_index;
   } cmd_type;

   typedef struct packed {
      logic offset_zero;
   } status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7, 8'h16, 8'hb6, 8'h14, 8'hc2,
      8'h28, 8'hfb, 8'h2c, 8'h05, 8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9c, 8'h42, 8'h50, 8'hf4,
      8'h91, 8'hef, 8'h98, 8'h7a, 8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95, 8'h80, 8'hdf, 8'h94, 8'hfa,
      8'h75, 8'h8f, 8'h3f, 8'ha6, 8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8, 8'h68, 8'h6b, 8'h81, 8'hb2,
      8'h71, 8'h64, 8'hda, 8'h8b, 8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2, 8'h25, 8'h22, 8'h7c, 8'h3b,
      8'h01, 8'h21, 8'h78, 8'h87, 8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e, 8'hea, 8'hbf, 8'h8a, 8'hd2,
      8'h40, 8'hc7, 8'h38, 8'hb5, 8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55, 8'had, 8'h93, 8'h32, 8'h30,
      8'hf5, 8'h8c, 8'hb1, 8'he3, 8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f, 8'hd5, 8'hdb, 8'h37, 8'h45,
      8'hde, 8'hfd, 8'h8e, 8'h2f, 8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f, 8'h11, 8'hd9, 8'h5c, 8'h41,
      8'h1f, 8'h10, 8'h5a, 8'hd8, 8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0, 8'h89, 8'h69, 8'h97, 8'h4a,
      8'h0c, 8'h96, 8'h77, 8'h7e, 8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20, 8'h79, 8'hee, 8'h5f, 8'h3e,
      8'hd7, 8'hcb, 8'h39, 8'h48
   };

   // Round transform: byte-wise S-box followed by the linear diffusion L.
   function automatic logic [31:0] sm4_t(input logic [31:0] x);
      logic [31:0] b;
      b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

endpackage

>>> design/sm4c_ctrl.sv
// Controller of the SM4 counter-mode core: state machine and round counter.
// Depends on sm4c_pkg; drives the datapath only through cmd_type.
`timescale 1ns / 1ps

module sm4c_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sm4c_pkg::status_type status,
   output sm4c_pkg::cmd_type    cmd
);
   import sm4c_pkg::*;

   state_type            state_ff, state_in;
   logic [RoundIdxW-1:0] round_ff, round_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      round_in        = round_ff;
      cmd             = '0;
      cmd.round_index = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (action_type'(req_action))
                  ACT_LOAD_KEY: cmd.load_key = 1'b1;
                  ACT_LOAD_CTR: cmd.load_ctr = 1'b1;
                  ACT_DATA: begin
                     if (status.offset_zero) begin
                        cmd.start_block = 1'b1;
                        round_in        = '0;
                        state_in        = ST_ROUND;
                     end else begin
                        cmd.emit = 1'b1;
                     end
                  end
                  ACT_UNUSED: ;
               endcase
            end
         end
         ST_ROUND: begin
            cmd.step_round = 1'b1;
            round_in       = round_ff + 1'b1;
            if (round_ff == RoundIdxW'(RoundCount - 1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_latched = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The output register is loaded on an emit and released by a transfer.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

>>> design/sm4c_datapath.sv
// Datapath of the SM4 counter-mode core: round keys, counter, round state, output byte.
// Depends on sm4c_pkg; controlled by cmd_type from sm4c_ctrl.
`timescale 1ns / 1ps

module sm4c_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sm4c_pkg::cmd_type    cmd,
   output sm4c_pkg::status_type status,
   input  logic [4:0]           req_word_index,
   input  logic [31:0]          req_word_value,
   input  logic [7:0]           req_data_byte,
   output logic [7:0]           rsp_out_byte
);
   import sm4c_pkg::*;

   logic [31:0]        round_key_ff [RoundCount];
   logic [127:0]       counter_ff, counter_in;
   logic [31:0]        w0_ff, w1_ff, w2_ff, w3_ff;
   logic [OffsetW-1:0] offset_ff, offset_in;
   logic [7:0]         data_ff;
   logic [7:0]         out_ff, out_in;
   logic [31:0]        round_t;
   logic [127:0]       keystream;
   logic [OffsetW-1:0] byte_sel;
   logic [7:0]         ks_byte;

   assign round_t   = w0_ff ^ sm4_t(w1_ff ^ w2_ff ^ w3_ff ^ round_key_ff[cmd.round_index]);
   // The last round leaves the keystream block in reversed word order.
   assign keystream = {w3_ff, w2_ff, w1_ff, w0_ff};
   assign byte_sel  = ~offset_ff;
   assign ks_byte   = keystream[{byte_sel, 3'b000} +: 8];

   assign status.offset_zero = (offset_ff == '0);
   assign rsp_out_byte       = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         round_key_ff[req_word_index] <= req_word_value;
      end
   end

   always_comb begin
      counter_in = counter_ff;
      offset_in  = offset_ff;
      out_in     = out_ff;
      if (cmd.load_ctr && req_word_index[4:2] == 3'd0) begin
         counter_in[{~req_word_index[1:0], 5'b00000} +: 32] = req_word_value;
         offset_in = '0;
      end
      if (cmd.start_block) begin
         counter_in = counter_ff + 128'd1;
      end
      if (cmd.emit) begin
         out_in    = (cmd.emit_latched ? data_ff : req_data_byte) ^ ks_byte;
         offset_in = offset_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         offset_ff  <= '0;
      end else begin
         counter_ff <= counter_in;
         offset_ff  <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.start_block) begin
         w0_ff   <= counter_ff[127:96];
         w1_ff   <= counter_ff[95:64];
         w2_ff   <= counter_ff[63:32];
         w3_ff   <= counter_ff[31:0];
         data_ff <= req_data_byte;
      end else if (cmd.step_round) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= w3_ff;
         w3_ff <= round_t;
      end
   end

endmodule

>>> design/sm4_ctr_stream_cipher_core.sv
// Top level of the SM4 counter-mode byte cipher core.
// Depends on sm4c_pkg, sm4c_ctrl and sm4c_datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_action, req_word_index, req_word_value,
//                                            req_data_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_out_byte
//
// Key and counter loads, and data bytes at a nonzero offset, complete in the idle state.
// A data byte at offset zero runs 32 SM4 rounds, one per cycle on a single round unit,
// then delivers its byte; the other bytes of its 16-byte block reuse that keystream.
// Reset is synchronous and active high; it clears the counter and the byte offset.
// A stalled output holds its byte in the output register and blocks the input until
// that byte is transferred.
`timescale 1ns / 1ps

module sm4_ctr_stream_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_word_value,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte
);
   import sm4c_pkg::*;

   cmd_type    cmd;
   status_type status;

   sm4c_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   sm4c_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .req_data_byte  (req_data_byte),
      .rsp_out_byte   (rsp_out_byte)
   );

endmodule
